>>> sv/nsf_pkg.sv
package nsf_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_DATA = 3'd2,
    PH_CK1  = 3'd3,
    PH_CK2  = 3'd4,
    PH_WAIT = 3'd5
  } phase_t;

  // Frame event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  localparam int unsigned LetterSlots = 9;

  // Address letter write from the parser
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [6:0] letter;
  } letter_wr_t;

  // Per-byte parse result
  typedef struct packed {
    logic       kept;
    event_t     ev;
    logic [6:0] stored_count;
    logic [3:0] letter_count;
    logic       had_checksum;
  } parse_res_t;

  function automatic logic is_hex_up(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

>>> sv/nsf_addr_buf.sv
module nsf_addr_buf
  import nsf_pkg::*;
#(
  parameter int unsigned DEPTH = 9
) (
  input  logic        clk,
  input  letter_wr_t  wr,
  input  logic [3:0]  letter_count,
  output logic [34:0] address_head,
  output logic [27:0] address_tail
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [6:0] letters [DEPTH];
  logic [6:0] slot [LetterSlots];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      letters[wr.idx[AW-1:0]] <= wr.letter;
    end
  end

  // letters past the captured count read as zero
  for (genvar i = 0; i < LetterSlots; i++) begin : g_slot
    if (i < DEPTH) begin : g_used
      assign slot[i] = (4'(i) < letter_count) ? letters[i] : 7'd0;
    end else begin : g_unused
      assign slot[i] = 7'd0;
    end
  end

  assign address_head = {slot[0], slot[1], slot[2], slot[3], slot[4]};
  assign address_tail = {slot[5], slot[6], slot[7], slot[8]};

endmodule

>>> sv/nsf_parser.sv
module nsf_parser
  import nsf_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 81,
  parameter int unsigned MAX_ADDRESS  = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] byte_in,
  output letter_wr_t wr,
  output parse_res_t res
);

  localparam logic [6:0] FullMark   = 7'(MAX_SENTENCE - 1);
  localparam logic [3:0] LetterMax  = 4'(MAX_ADDRESS - 1);

  phase_t     phase, phase_next;
  logic [6:0] stored_count, stored_count_next;
  logic [3:0] letter_count, letter_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [3:0] ck_high, ck_high_next;
  logic       had_ck, had_ck_next;
  logic       full;
  logic       kept;
  event_t     ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      stored_count <= '0;
      letter_count <= '0;
      running_xor  <= '0;
      ck_high      <= '0;
      had_ck       <= 1'b0;
    end else begin
      phase        <= phase_next;
      stored_count <= stored_count_next;
      letter_count <= letter_count_next;
      running_xor  <= running_xor_next;
      ck_high      <= ck_high_next;
      had_ck       <= had_ck_next;
    end
  end

  assign full = (stored_count >= FullMark);

  always_comb begin
    phase_next        = phase;
    stored_count_next = stored_count;
    letter_count_next = letter_count;
    running_xor_next  = running_xor;
    ck_high_next      = ck_high;
    had_ck_next       = had_ck;
    kept              = 1'b0;
    ev                = EV_NONE;
    wr                = '0;
    if (adv) begin
      unique case (phase)
        PH_HUNT: begin
          if (byte_in == CH_DOLLAR) begin
            stored_count_next = '0;
            letter_count_next = '0;
            running_xor_next  = '0;
            ck_high_next      = '0;
            had_ck_next       = 1'b0;
            phase_next        = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (full) begin
            ev = EV_ABORT;
          end else begin
            stored_count_next = stored_count + 7'd1;
            kept              = 1'b1;
            running_xor_next  = running_xor ^ byte_in;
            if (byte_in == CH_COMMA) begin
              phase_next = PH_DATA;
            end else if ((letter_count >= LetterMax) || (byte_in < CH_UA) ||
                         (byte_in > CH_UZ)) begin
              ev = EV_ABORT;
            end else begin
              wr.en             = 1'b1;
              wr.idx            = letter_count;
              wr.letter         = byte_in[6:0];
              letter_count_next = letter_count + 4'd1;
            end
          end
        end
        PH_DATA: begin
          if (full) begin
            ev = EV_ABORT;
          end else begin
            stored_count_next = stored_count + 7'd1;
            kept              = 1'b1;
            if (byte_in == CH_STAR) begin
              phase_next = PH_CK1;
            end else if (byte_in == CH_LF) begin
              phase_next = PH_WAIT;
            end else if (byte_in == CH_CR) begin
              ev = EV_DONE;
            end else begin
              running_xor_next = running_xor ^ byte_in;
            end
          end
        end
        PH_CK1: begin
          if (full || !is_hex_up(byte_in)) begin
            ev = EV_ABORT;
          end else begin
            stored_count_next = stored_count + 7'd1;
            kept              = 1'b1;
            ck_high_next      = hex_val(byte_in);
            phase_next        = PH_CK2;
          end
        end
        PH_CK2: begin
          if (full || !is_hex_up(byte_in)) begin
            ev = EV_ABORT;
          end else begin
            stored_count_next = stored_count + 7'd1;
            kept              = 1'b1;
            if ({ck_high, hex_val(byte_in)} == running_xor) begin
              had_ck_next = 1'b1;
              phase_next  = PH_WAIT;
            end else begin
              ev = EV_ABORT;
            end
          end
        end
        PH_WAIT: begin
          if (full || ((byte_in != CH_LF) && (byte_in != CH_CR))) begin
            ev = EV_ABORT;
          end else if (byte_in == CH_CR) begin
            stored_count_next = stored_count + 7'd1;
            kept              = 1'b1;
            ev                = EV_DONE;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
      if (ev != EV_NONE) begin
        phase_next = PH_HUNT;
      end
    end
  end

  // letter count never moves on an event cycle, so the register is current
  assign res.kept         = kept;
  assign res.ev           = ev;
  assign res.stored_count = stored_count_next;
  assign res.letter_count = letter_count;
  assign res.had_checksum = had_ck_next;

endmodule

>>> sv/nmea_sentence_framer.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata[7:0] byte_in
// m_axis    out  tdata: byte_kept[0], sentence_length[7:1], address_length[11:8],
//                address_head[46:12], address_tail[74:47], checksum_verified[75],
//                zero[79:76]; tuser[1:0] frame_event
//
// One result per input byte, one byte per cycle sustained while the output is not
// stalled. The result is registered: an input register feeds the parser, whose
// result lands in the output register.
// rst (synchronous) returns the parser to hunting for '$'; address letters are
// not cleared. A stalled output holds its result; the input register still takes
// one more byte, then s_axis_tready drops until the output drains.
module nmea_sentence_framer
  import nsf_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 81,
  parameter int unsigned MAX_ADDRESS  = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // see table above
  output logic [1:0]  m_axis_tuser    // frame_event
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  // parser outputs
  letter_wr_t  wr;
  parse_res_t  res;
  logic [34:0] addr_head;
  logic [27:0] addr_tail;

  // output register
  logic        out_kept;
  event_t      out_ev;
  logic [6:0]  out_len;
  logic [3:0]  out_alen;
  logic [34:0] out_head;
  logic [27:0] out_tail;
  logic        out_ck;
  logic        has_event;

  // the byte in the input register is parsed when the output slot is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  nsf_parser #(
    .MAX_SENTENCE (MAX_SENTENCE),
    .MAX_ADDRESS  (MAX_ADDRESS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .adv     (advance),
    .byte_in (in_byte),
    .wr      (wr),
    .res     (res)
  );

  // at most MAX_ADDRESS-1 letters are ever kept
  nsf_addr_buf #(
    .DEPTH (MAX_ADDRESS - 1)
  ) u_addr (
    .clk          (clk),
    .wr           (wr),
    .letter_count (res.letter_count),
    .address_head (addr_head),
    .address_tail (addr_tail)
  );

  assign has_event = (res.ev != EV_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // frame fields read as zero unless an event fires
  always_ff @(posedge clk) begin
    if (advance) begin
      out_kept <= res.kept;
      out_ev   <= res.ev;
      out_len  <= has_event ? res.stored_count : 7'd0;
      out_alen <= has_event ? res.letter_count : 4'd0;
      out_head <= has_event ? addr_head : 35'd0;
      out_tail <= has_event ? addr_tail : 28'd0;
      out_ck   <= (res.ev == EV_DONE) && res.had_checksum;
    end
  end

  assign m_axis_tdata = {4'd0, out_ck, out_tail, out_head, out_alen, out_len, out_kept};
  assign m_axis_tuser = out_ev;

  // a held input byte stays put while the output is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input register lost a byte while stalled");

  // no event means all frame fields are zero
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_NONE) |-> (m_axis_tdata[79:1] == 79'd0))
    else $error("frame fields set without an event");

  // checksum flag only on a delivered sentence
  a_ck_on_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[75] |-> (m_axis_tuser == EV_DONE))
    else $error("checksum flag outside a delivered sentence");

  // a result only appears when a byte was waiting in the input register
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> !$rose(m_axis_tvalid))
    else $error("result produced with no byte buffered");

endmodule
